// ===== src/atsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Alarm table snooze controller package
// Shared codes, the table entry layout and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package atsc_pkg;

    // Operation codes of an input transaction.
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_DEL  = 3'd1;
    localparam logic [2:0] OP_EDIT = 3'd2;
    localparam logic [2:0] OP_TCHK = 3'd3;
    localparam logic [2:0] OP_TICK = 3'd4;
    localparam logic [2:0] OP_STOP = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TIME  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    // Entry modes.
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_RING = 2'd1;
    localparam logic [1:0] MODE_WAIT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RING_TICKS   = 2'd0;
    localparam logic [1:0] CFG_WAIT_TICKS   = 2'd1;
    localparam logic [1:0] CFG_SNOOZE_LIMIT = 2'd2;

    // Largest hour and minute accepted by an add.
    localparam logic [4:0] HOUR_MAX   = 5'd24;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [4:0] SNOOZE_SAT = 5'd31;

    typedef struct packed {
        logic [7:0]  key;
        logic [16:0] secs;
        logic        rep;
        logic [1:0]  mode;
        logic [7:0]  ring;
        logic [7:0]  wait_cnt;
        logic [4:0]  snooze;
    } t_entry;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ADD,
        CMD_EMPTY,
        CMD_NOTFOUND,
        CMD_FIND_STEP,
        CMD_EDIT,
        CMD_FETCH,
        CMD_REMOVE,
        CMD_TCHK_STEP,
        CMD_TICK_STEP,
        CMD_STOP_STEP,
        CMD_PUBLISH
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       scan_end;
        logic       idx_end;
        logic       count_zero;
        logic       key_hit;
        logic       time_hit;
        logic       tick_brk;
        logic       stop_del;
    } t_dp_status;

    // Seconds of day for an hour and a minute.
    function automatic logic [16:0] day_secs(input logic [4:0] hr, input logic [5:0] mn);
        logic [16:0] h;
        logic [16:0] m;
        h = {12'd0, hr} * 17'd3600;
        m = {11'd0, mn} * 17'd60;
        return h + m;
    endfunction

endpackage

`default_nettype wire

// ===== src/alarm_table_snooze_controller_top.sv =====
// ----------------------------------------------------------------------------
// Alarm table snooze controller
// Table of alarms with add, delete, edit, time check, ring tick and stop.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one operation per transaction.
// Output channel: o_out_valid / i_out_stall carry exactly one result per
// input transaction, in order. The configuration port writes ring_ticks,
// wait_ticks and snooze_limit at index 0, 1 and 2; the user must write them
// only while the block is idle, which the block itself does not enforce.
// An operation is taken only when the controller is idle; it is then walked
// over the table one slot per cycle by the controller. Add, unused codes and
// an empty table need no scan; a delete, edit, time check or ring tick scans
// the table, and a stop rescans it for each non-repeating alarm it silences.
// The single table read port limits each scan step to one slot.
// The result sits in an output register; a new operation is accepted while
// it waits, but the next result waits while the receiver stalls.
// Synchronous reset clears the table, the count and the output valid, and
// loads the configuration defaults 30, 60 and 2.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_table_snooze_controller_top #(
    parameter int ALARM_SLOTS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire [2:0]   i_op,
    input  wire [7:0]   i_alarm_key,
    input  wire [4:0]   i_hour,
    input  wire [5:0]   i_minute,
    input  wire         i_repeat_req,
    input  wire [16:0]  i_now_seconds,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_buzzer_start,
    output logic        o_buzzer_stop,
    output logic [$clog2(ALARM_SLOTS+1)-1:0] o_matched_slot,
    output logic [$clog2(ALARM_SLOTS+1)-1:0] o_alarm_count,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_index,
    input  wire [7:0]   i_cfg_data
);
    import atsc_pkg::*;

    localparam int CW = $clog2(ALARM_SLOTS + 1);

    t_cmd       cmd;
    t_dp_status st;

    // Controller.
    atsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    // Datapath.
    atsc_datapath #(
        .ALARM_SLOTS (ALARM_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_alarm_key    (i_alarm_key),
        .i_hour         (i_hour),
        .i_minute       (i_minute),
        .i_repeat_req   (i_repeat_req),
        .i_now_seconds  (i_now_seconds),
        .o_status       (o_status),
        .o_buzzer_start (o_buzzer_start),
        .o_buzzer_stop  (o_buzzer_stop),
        .o_matched_slot (o_matched_slot),
        .o_alarm_count  (o_alarm_count)
    );

    // An accepted transaction keeps the input side busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a transaction was in progress");

    // The stored count never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_alarm_count <= CW'(ALARM_SLOTS)))
        else $error("alarm count beyond table size");

    // A failed add or lookup reports no slot.
    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL || o_status == ST_BAD_TIME ||
         o_status == ST_NOT_FOUND || o_status == ST_EMPTY))
        |-> (o_matched_slot == CW'(ALARM_SLOTS)))
        else $error("slot reported for a failed transaction");

endmodule

`default_nettype wire

// ===== src/atsc_datapath.sv =====
// ----------------------------------------------------------------------------
// Alarm table datapath
// Holds the alarm table, the configuration and the working registers, and
// carries out one controller command per cycle over one table slot.
// ----------------------------------------------------------------------------
`default_nettype none

module atsc_datapath #(
    parameter int ALARM_SLOTS = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  atsc_pkg::t_cmd      i_cmd,
    output atsc_pkg::t_dp_status o_st,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_index,
    input  wire [7:0]           i_cfg_data,
    input  wire [2:0]           i_op,
    input  wire [7:0]           i_alarm_key,
    input  wire [4:0]           i_hour,
    input  wire [5:0]           i_minute,
    input  wire                 i_repeat_req,
    input  wire [16:0]          i_now_seconds,
    output logic [2:0]          o_status,
    output logic                o_buzzer_start,
    output logic                o_buzzer_stop,
    output logic [$clog2(ALARM_SLOTS+1)-1:0] o_matched_slot,
    output logic [$clog2(ALARM_SLOTS+1)-1:0] o_alarm_count
);
    import atsc_pkg::*;

    localparam int CW = $clog2(ALARM_SLOTS + 1);
    localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam logic [CW-1:0] NONE = CW'(ALARM_SLOTS);

    t_entry          r_tab [ALARM_SLOTS];
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_scan;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_del;
    logic [CW-1:0]   r_slot;
    t_entry          r_hold;
    logic [2:0]      r_status;
    logic            r_bstart;
    logic            r_bstop;
    logic [7:0]      r_ring_ticks;
    logic [7:0]      r_wait_ticks;
    logic [3:0]      r_snooze_limit;
    logic [2:0]      r_op;
    logic [7:0]      r_key;
    logic [7:0]      r_skey;
    logic [4:0]      r_hour;
    logic [5:0]      r_minute;
    logic            r_rep;
    logic [16:0]     r_now;

    logic [CW-1:0]   last;
    logic [CW-1:0]   rd_addr;
    t_entry          rd;
    t_entry          tk;
    logic            tk_start;
    logic            tk_stop;
    logic            tk_brk;
    t_entry          fill;
    logic            bad_time;

    // Single read port of the table.
    assign last = r_count - 1'b1;
    always_comb begin
        case (i_cmd)
            CMD_FETCH:     rd_addr = last;
            CMD_FIND_STEP: rd_addr = r_idx;
            default:       rd_addr = r_scan;
        endcase
        rd = r_tab[rd_addr[AW-1:0]];
    end

    // New entry for add and edit.
    always_comb begin
        fill          = '0;
        fill.key      = r_key;
        fill.secs     = day_secs(r_hour, r_minute);
        fill.rep      = r_rep;
        fill.mode     = MODE_OFF;
        bad_time      = (r_hour > HOUR_MAX) || (r_hour == 5'd0) || (r_minute > MINUTE_MAX);
    end

    // One slot of a ring tick.
    always_comb begin
        tk       = rd;
        tk_start = 1'b0;
        tk_stop  = 1'b0;
        tk_brk   = 1'b0;
        if (tk.mode == MODE_RING) begin
            tk.ring = tk.ring + 8'd1;
        end
        if (tk.ring >= r_ring_ticks) begin
            tk.ring = 8'd0;
            tk_stop = 1'b1;
            tk.mode = MODE_WAIT;
            if (tk.snooze < SNOOZE_SAT) begin
                tk.snooze = tk.snooze + 5'd1;
            end
        end
        if (tk.mode == MODE_WAIT) begin
            if (tk.snooze > {1'b0, r_snooze_limit}) begin
                tk.mode   = MODE_OFF;
                tk.snooze = 5'd0;
                tk_brk    = 1'b1;
            end else begin
                tk.wait_cnt = tk.wait_cnt + 8'd1;
                if (tk.wait_cnt >= r_wait_ticks) begin
                    tk.wait_cnt = 8'd0;
                    tk.mode     = MODE_RING;
                    tk_start    = 1'b1;
                end
            end
        end
    end

    // Status towards the controller.
    always_comb begin
        o_st.op         = r_op;
        o_st.scan_end   = (r_scan >= r_count);
        o_st.idx_end    = (r_idx >= r_count);
        o_st.count_zero = (r_count == '0);
        o_st.key_hit    = (rd.key == r_skey);
        o_st.time_hit   = (rd.secs == r_now);
        o_st.tick_brk   = tk_brk;
        o_st.stop_del   = (rd.mode == MODE_RING) && !rd.rep;
    end

    // Table, configuration and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ALARM_SLOTS; s++) begin
                r_tab[s] <= '0;
            end
            r_count        <= '0;
            r_ring_ticks   <= 8'd30;
            r_wait_ticks   <= 8'd60;
            r_snooze_limit <= 4'd2;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RING_TICKS:   r_ring_ticks   <= i_cfg_data;
                    CFG_WAIT_TICKS:   r_wait_ticks   <= i_cfg_data;
                    CFG_SNOOZE_LIMIT: r_snooze_limit <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            case (i_cmd)
                CMD_LOAD: begin
                    r_op     <= i_op;
                    r_key    <= i_alarm_key;
                    r_skey   <= i_alarm_key;
                    r_hour   <= i_hour;
                    r_minute <= i_minute;
                    r_rep    <= i_repeat_req;
                    r_now    <= i_now_seconds;
                    r_idx    <= '0;
                    r_scan   <= '0;
                    r_status <= ST_OK;
                    r_bstart <= 1'b0;
                    r_bstop  <= 1'b0;
                    r_slot   <= NONE;
                end
                CMD_ADD: begin
                    if (bad_time) begin
                        r_status <= ST_BAD_TIME;
                    end else if (r_count >= NONE) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_tab[r_count[AW-1:0]] <= fill;
                        r_slot  <= r_count;
                        r_count <= r_count + 1'b1;
                    end
                end
                CMD_EMPTY:    r_status <= ST_EMPTY;
                CMD_NOTFOUND: r_status <= ST_NOT_FOUND;
                CMD_FIND_STEP: begin
                    if (o_st.key_hit) begin
                        r_del <= r_idx;
                        if (r_op != OP_STOP) begin
                            r_slot <= r_idx;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                end
                CMD_EDIT:  r_tab[r_del[AW-1:0]] <= fill;
                CMD_FETCH: r_hold <= rd;
                CMD_REMOVE: begin
                    // Move the last entry into the freed slot, unless the freed
                    // slot is the last one, and clear the last slot.
                    if (r_del != last) begin
                        r_tab[r_del[AW-1:0]] <= r_hold;
                    end
                    r_tab[last[AW-1:0]] <= '0;
                    r_count             <= last;
                end
                CMD_TCHK_STEP: begin
                    if (o_st.time_hit) begin
                        r_slot <= r_scan;
                        if (rd.mode == MODE_OFF) begin
                            r_tab[r_scan[AW-1:0]].mode <= MODE_RING;
                            r_bstart <= 1'b1;
                        end
                    end
                    r_scan <= r_scan + 1'b1;
                end
                CMD_TICK_STEP: begin
                    r_tab[r_scan[AW-1:0]] <= tk;
                    r_bstart <= r_bstart | tk_start;
                    r_bstop  <= r_bstop | tk_stop;
                    if (tk_start && (r_slot == NONE)) begin
                        r_slot <= r_scan;
                    end
                    r_scan <= r_scan + 1'b1;
                end
                CMD_STOP_STEP: begin
                    if (rd.mode == MODE_RING) begin
                        r_tab[r_scan[AW-1:0]].mode <= MODE_OFF;
                        r_bstop <= 1'b1;
                        r_skey  <= rd.key;
                        r_idx   <= '0;
                    end
                    r_scan <= r_scan + 1'b1;
                end
                CMD_PUBLISH: begin
                    o_status       <= r_status;
                    o_buzzer_start <= r_bstart;
                    o_buzzer_stop  <= r_bstop;
                    o_matched_slot <= r_slot;
                    o_alarm_count  <= r_count;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/atsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Alarm table controller
// Sequences the datapath through the slot scans of each operation and owns
// the handshake of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module atsc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    input  atsc_pkg::t_dp_status i_st,
    output atsc_pkg::t_cmd       o_cmd
);
    import atsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FIND, S_EDIT, S_FETCH, S_REMOVE,
        S_TCHK, S_TICK, S_STOP, S_SFIND, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and command.
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_st.op) inside
                    OP_ADD: begin
                        o_cmd   = CMD_ADD;
                        n_state = S_DONE;
                    end
                    OP_DEL, OP_EDIT: begin
                        if (i_st.count_zero) begin
                            o_cmd   = CMD_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_FIND;
                        end
                    end
                    OP_TCHK: n_state = S_TCHK;
                    OP_TICK: n_state = S_TICK;
                    OP_STOP: n_state = S_STOP;
                    default: n_state = S_DONE;
                endcase
            end
            S_FIND: begin
                if (i_st.idx_end) begin
                    o_cmd   = CMD_NOTFOUND;
                    n_state = S_DONE;
                end else begin
                    o_cmd = CMD_FIND_STEP;
                    if (i_st.key_hit) begin
                        n_state = (i_st.op == OP_DEL) ? S_FETCH : S_EDIT;
                    end
                end
            end
            S_EDIT: begin
                o_cmd   = CMD_EDIT;
                n_state = S_DONE;
            end
            S_FETCH: begin
                o_cmd   = CMD_FETCH;
                n_state = S_REMOVE;
            end
            S_REMOVE: begin
                o_cmd   = CMD_REMOVE;
                n_state = (i_st.op == OP_STOP) ? S_STOP : S_DONE;
            end
            S_TCHK: begin
                if (i_st.scan_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd = CMD_TCHK_STEP;
                    if (i_st.time_hit) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TICK: begin
                if (i_st.scan_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd = CMD_TICK_STEP;
                    if (i_st.tick_brk) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_STOP: begin
                if (i_st.scan_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd = CMD_STOP_STEP;
                    if (i_st.stop_del) begin
                        n_state = S_SFIND;
                    end
                end
            end
            S_SFIND: begin
                if (i_st.idx_end) begin
                    n_state = S_STOP;
                end else begin
                    o_cmd = CMD_FIND_STEP;
                    if (i_st.key_hit) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_DONE: begin
                // The output register is free or is emptied at this edge.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd       = CMD_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Alarm table snooze controller testbench
// A directed table of operations drives the block first, then random traffic
// of mostly well-formed operations of every kind. Every result is checked
// field by field against an in-bench model of the alarm table.
// Configuration is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import atsc_pkg::*;

    localparam int SLOTS       = 8;
    localparam int NONE_SLOT   = SLOTS;
    localparam int CYCLE_LIMIT = 900000;
    localparam int DRAIN_WAIT  = SLOTS * (SLOTS + 4) + 20;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] key;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       rep;
        logic [16:0] now;
    } t_op_item;

    typedef struct packed {
        logic [2:0] status;
        logic       bstart;
        logic       bstop;
        logic [3:0] slot;
        logic [3:0] count;
    } t_outcome;

    // Directed row: an operation and, where obvious, its typed result.
    typedef struct packed {
        t_op_item   item;
        logic       typed;
        t_outcome   res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_op;
    logic [7:0]  i_alarm_key;
    logic [4:0]  i_hour;
    logic [5:0]  i_minute;
    logic        i_repeat_req;
    logic [16:0] i_now_seconds;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic        o_buzzer_start;
    logic        o_buzzer_stop;
    logic [3:0]  o_matched_slot;
    logic [3:0]  o_alarm_count;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    alarm_table_snooze_controller_top #(.ALARM_SLOTS(SLOTS)) DUT (.*);

    // Model state of the alarm table.
    t_entry     tbl [SLOTS];
    int         tbl_count;
    logic [7:0] cfg_ring;
    logic [7:0] cfg_wait;
    logic [3:0] cfg_snooze;

    t_outcome   pending_results [$];
    t_outcome   typed_results [$];
    logic       typed_flag [$];
    int         mismatch_count;
    int         cycle_count;
    bit         hold_off;
    bit         calm;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_entry blank_entry();
        t_entry e;
        e = '0;
        e.mode = MODE_OFF;
        return e;
    endfunction

    function automatic int key_slot(logic [7:0] key);
        for (int i = 0; i < tbl_count; i++)
            if (tbl[i].key == key) return i;
        return NONE_SLOT;
    endfunction

    task automatic drop_slot(int s);
        tbl[s] = tbl[tbl_count - 1];
        tbl[tbl_count - 1] = blank_entry();
        tbl_count--;
    endtask

    function automatic t_entry fresh_entry(t_op_item it);
        t_entry e;
        e = blank_entry();
        e.key = it.key;
        e.secs = 17'(it.hour * 3600 + it.minute * 60);
        e.rep = it.rep;
        return e;
    endfunction

    // Applies one operation to the model table and returns its result.
    task automatic apply_alarm_op(input t_op_item it, output t_outcome r);
        int s;
        r = '0;
        r.status = ST_OK;
        r.slot = 4'(NONE_SLOT);
        case (it.op)
            OP_ADD: begin
                if (it.hour > HOUR_MAX || it.hour < 1 || it.minute > MINUTE_MAX)
                    r.status = ST_BAD_TIME;
                else if (tbl_count >= SLOTS)
                    r.status = ST_FULL;
                else begin
                    r.slot = 4'(tbl_count);
                    tbl[tbl_count] = fresh_entry(it);
                    tbl_count++;
                end
            end
            OP_DEL, OP_EDIT: begin
                if (tbl_count == 0)
                    r.status = ST_EMPTY;
                else begin
                    s = key_slot(it.key);
                    if (s == NONE_SLOT)
                        r.status = ST_NOT_FOUND;
                    else begin
                        r.slot = 4'(s);
                        if (it.op == OP_DEL) drop_slot(s);
                        else tbl[s] = fresh_entry(it);
                    end
                end
            end
            OP_TCHK: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl[i].secs == it.now) begin
                        r.slot = 4'(i);
                        if (tbl[i].mode == MODE_OFF) begin
                            tbl[i].mode = MODE_RING;
                            r.bstart = 1'b1;
                        end
                        break;
                    end
                end
            end
            OP_TICK: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl[i].mode == MODE_RING) tbl[i].ring = tbl[i].ring + 8'd1;
                    if (tbl[i].ring >= cfg_ring) begin
                        tbl[i].ring = '0;
                        r.bstop = 1'b1;
                        tbl[i].mode = MODE_WAIT;
                        if (tbl[i].snooze < SNOOZE_SAT) tbl[i].snooze++;
                    end
                    if (tbl[i].mode == MODE_WAIT) begin
                        if (tbl[i].snooze > {1'b0, cfg_snooze}) begin
                            tbl[i].mode = MODE_OFF;
                            tbl[i].snooze = '0;
                            break;
                        end
                        tbl[i].wait_cnt = tbl[i].wait_cnt + 8'd1;
                        if (tbl[i].wait_cnt >= cfg_wait) begin
                            tbl[i].wait_cnt = '0;
                            tbl[i].mode = MODE_RING;
                            r.bstart = 1'b1;
                            if (r.slot == 4'(NONE_SLOT)) r.slot = 4'(i);
                        end
                    end
                end
            end
            OP_STOP: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl[i].mode == MODE_RING) begin
                        r.bstop = 1'b1;
                        tbl[i].mode = MODE_OFF;
                        if (!tbl[i].rep) begin
                            s = key_slot(tbl[i].key);
                            if (s != NONE_SLOT) drop_slot(s);
                        end
                    end
                end
            end
            default: ;
        endcase
        r.count = 4'(tbl_count);
    endtask

    // Result checker: compare every accepted result with the oldest one due.
    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_status, o_buzzer_start, o_buzzer_stop, o_matched_slot,
                    o_alarm_count};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (typed_flag.pop_front() && typed_results[0] != want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("table row %p disagrees with model %p",
                                 typed_results[0], want);
                end
                void'(typed_results.pop_front());
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Receiver stall: random, with one calm stretch and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= hold_off || (!calm && $urandom_range(99) < 9);
    end

    // Sender: drives one transaction and waits for it to be accepted. Valid
    // stays high between back-to-back transactions and drops only while idling.
    task automatic send_op(input t_op_item it, input bit typed, input t_outcome res);
        t_outcome r;
        bit idle;
        idle = !calm && ($urandom_range(99) < 9);
        if (idle) i_in_valid <= 1'b0;
        while (idle) begin
            @(posedge i_clk);
            idle = !calm && ($urandom_range(99) < 9);
        end
        i_in_valid    <= 1'b1;
        i_op          <= it.op;
        i_alarm_key   <= it.key;
        i_hour        <= it.hour;
        i_minute      <= it.minute;
        i_repeat_req  <= it.rep;
        i_now_seconds <= it.now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_alarm_op(it, r);
        pending_results.push_back(r);
        typed_flag.push_back(typed);
        typed_results.push_back(res);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write enable stays high over consecutive writes; the caller drops it.
    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_RING_TICKS:   cfg_ring = val;
            CFG_WAIT_TICKS:   cfg_wait = val;
            CFG_SNOOZE_LIMIT: cfg_snooze = val[3:0];
            default: ;
        endcase
    endtask

    function automatic t_op_item mk(logic [2:0] op, logic [7:0] key, logic [4:0] hr,
                                    logic [5:0] mn, logic rep, logic [16:0] now);
        return '{op, key, hr, mn, rep, now};
    endfunction

    function automatic t_outcome res(logic [2:0] st, logic [3:0] slot, logic [3:0] cnt);
        return '{st, 1'b0, 1'b0, slot, cnt};
    endfunction

    // Random operation on a small key range, with time checks biased toward times already in the table.
    function automatic t_op_item random_op();
        t_op_item it;
        int pick;
        it = mk(3'($urandom_range(5)), 8'($urandom_range(7)),
                5'($urandom_range(1, 24)), 6'($urandom_range(59)),
                1'($urandom), 17'($urandom_range(3)));
        pick = $urandom_range(99);
        if (pick < 5) begin
            it.op = 3'($urandom_range(7));
            it.key = 8'($urandom);
            it.hour = 5'($urandom);
            it.minute = 6'($urandom);
            it.now = 17'($urandom);
        end else if (pick < 30) it.op = OP_TICK;
        if (it.op == OP_TCHK && tbl_count != 0 && $urandom_range(3) != 0)
            it.now = tbl[$urandom_range(tbl_count - 1)].secs;
        else if (it.op == OP_TCHK && $urandom_range(1)) it.now = 17'($urandom);
        if (it.op == OP_ADD && $urandom_range(9) == 0) it.hour = 5'($urandom);
        return it;
    endfunction

    initial begin
        t_row rows [$];
        t_op_item it;
        cycle_count = 0;
        mismatch_count = 0;
        hold_off = 1'b0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_ADD;
        i_alarm_key = '0;
        i_hour = '0;
        i_minute = '0;
        i_repeat_req = 1'b0;
        i_now_seconds = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_RING_TICKS;
        i_cfg_data = '0;
        i_out_stall = 1'b0;
        cfg_ring = 8'd30;
        cfg_wait = 8'd60;
        cfg_snooze = 4'd2;
        tbl_count = 0;
        for (int i = 0; i < SLOTS; i++) tbl[i] = blank_entry();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: error codes, time extremes, every operation.
        rows.push_back('{mk(OP_DEL, 8'd5, 0, 0, 0, 0), 1'b1, res(ST_EMPTY, 8, 0)});
        rows.push_back('{mk(OP_EDIT, 8'd5, 1, 0, 0, 0), 1'b1, res(ST_EMPTY, 8, 0)});
        rows.push_back('{mk(OP_ADD, 8'd1, 0, 0, 0, 0), 1'b1, res(ST_BAD_TIME, 8, 0)});
        rows.push_back('{mk(OP_ADD, 8'd1, 25, 0, 0, 0), 1'b1, res(ST_BAD_TIME, 8, 0)});
        rows.push_back('{mk(OP_ADD, 8'd1, 31, 63, 1, 0), 1'b1, res(ST_BAD_TIME, 8, 0)});
        rows.push_back('{mk(OP_ADD, 8'd1, 3, 60, 0, 0), 1'b1, res(ST_BAD_TIME, 8, 0)});
        rows.push_back('{mk(OP_ADD, 8'd0, 1, 0, 0, 0), 1'b1, res(ST_OK, 0, 1)});
        rows.push_back('{mk(OP_ADD, 8'd255, 24, 59, 1, 0), 1'b1, res(ST_OK, 1, 2)});
        rows.push_back('{mk(OP_ADD, 8'd7, 2, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(OP_DEL, 8'd99, 0, 0, 0, 0), 1'b1, res(ST_NOT_FOUND, 8, 3)});
        rows.push_back('{mk(OP_TCHK, 0, 0, 0, 0, 17'd3600), 1'b0, '0});
        rows.push_back('{mk(OP_TCHK, 0, 0, 0, 0, 17'd89940), 1'b0, '0});
        rows.push_back('{mk(OP_TCHK, 0, 0, 0, 0, 17'h1FFFF), 1'b0, '0});
        rows.push_back('{mk(OP_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(OP_STOP, 0, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(OP_EDIT, 8'd255, 31, 63, 0, 0), 1'b0, '0});
        rows.push_back('{mk(3'd6, 8'hAA, 5'h15, 6'h2A, 1, 17'h15555), 1'b0, '0});
        rows.push_back('{mk(3'd7, 8'h55, 5'h0A, 6'h15, 0, 17'h0AAAA), 1'b0, '0});
        for (int k = 0; k < 6; k++)
            rows.push_back('{mk(OP_ADD, 8'(10 + k), 5, 6'(k), 0, 0), 1'b0, '0});
        rows.push_back('{mk(OP_ADD, 8'd20, 6, 0, 0, 0), 1'b1, res(ST_FULL, 8, 8)});
        rows.push_back('{mk(OP_DEL, 8'd0, 0, 0, 0, 0), 1'b0, '0});
        foreach (rows[r]) send_op(rows[r].item, rows[r].typed, rows[r].res);
        drain();

        // Random phases under several settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_RING_TICKS, 1); write_cfg(CFG_WAIT_TICKS, 1);
                         write_cfg(CFG_SNOOZE_LIMIT, 0); end
                1: begin write_cfg(CFG_RING_TICKS, 255); write_cfg(CFG_WAIT_TICKS, 255);
                         write_cfg(CFG_SNOOZE_LIMIT, 15); end
                2: begin write_cfg(CFG_RING_TICKS, 3); write_cfg(CFG_WAIT_TICKS, 2);
                         write_cfg(CFG_SNOOZE_LIMIT, 15); end
                default: begin
                    write_cfg(CFG_RING_TICKS, 8'($urandom_range(1, 6)));
                    write_cfg(CFG_WAIT_TICKS, 8'($urandom_range(1, 6)));
                    write_cfg(CFG_SNOOZE_LIMIT, 8'($urandom_range(15)));
                end
            endcase
            i_cfg_we <= 1'b0;
            calm = (ph == 3);
            if (ph == 4) begin
                // Long receiver hold-off while items keep coming.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 280; n++) begin
                it = random_op();
                send_op(it, 1'b0, '0);
            end
            calm = 1'b0;
            drain();
        end

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
